@@ sv/sab_pkg.sv @@
// ----------------------------------------------------------------------------
// sab_pkg
// Shared types and constants for the straight-alpha blend unit.
// ----------------------------------------------------------------------------
package sab_pkg;

    // Default fixed-point fraction width of the blend arithmetic
    localparam int SAB_FRACTION_BITS = 16;

    // Width of one color or alpha channel on the ports
    localparam int SAB_BYTE_W = 8;

    // Blend mode codes
    typedef enum logic [1:0] {
        MODE_NORMAL   = 2'd0,
        MODE_ERASE    = 2'd1,
        MODE_ADD      = 2'd2,
        MODE_MULTIPLY = 2'd3
    } blend_mode_t;

endpackage

@@ sv/sab_in_if.sv @@
// ----------------------------------------------------------------------------
// sab_in_if
// Pixel input channel: blend mode, destination pixel, source color, amount.
// ----------------------------------------------------------------------------
interface sab_in_if
    import sab_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [1:0]            func;
    logic [SAB_BYTE_W-1:0] dst_red;
    logic [SAB_BYTE_W-1:0] dst_green;
    logic [SAB_BYTE_W-1:0] dst_blue;
    logic [SAB_BYTE_W-1:0] dst_alpha;
    logic [SAB_BYTE_W-1:0] src_red;
    logic [SAB_BYTE_W-1:0] src_green;
    logic [SAB_BYTE_W-1:0] src_blue;
    logic [SAB_BYTE_W-1:0] src_alpha;
    logic [SAB_BYTE_W-1:0] amount;

    modport source (
        output valid, func, dst_red, dst_green, dst_blue, dst_alpha,
               src_red, src_green, src_blue, src_alpha, amount,
        input  ready
    );

    modport sink (
        input  valid, func, dst_red, dst_green, dst_blue, dst_alpha,
               src_red, src_green, src_blue, src_alpha, amount,
        output ready
    );
endinterface

@@ sv/sab_out_if.sv @@
// ----------------------------------------------------------------------------
// sab_out_if
// Pixel output channel: blended RGBA bytes and the changed flag.
// ----------------------------------------------------------------------------
interface sab_out_if
    import sab_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [SAB_BYTE_W-1:0] out_red;
    logic [SAB_BYTE_W-1:0] out_green;
    logic [SAB_BYTE_W-1:0] out_blue;
    logic [SAB_BYTE_W-1:0] out_alpha;
    logic                  changed;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha, changed,
        input  ready
    );

    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha, changed,
        output ready
    );
endinterface

@@ sv/sab_divider.sv @@
// ----------------------------------------------------------------------------
// sab_divider
// Pipelined restoring divider, three lanes sharing one divisor. Computes
// floor((num * 2^F + den/2) / den), one quotient bit per stage, and carries
// a side word along with each beat.
// ----------------------------------------------------------------------------
module sab_divider
    import sab_pkg::*;
#(
    parameter int FRAC_BITS = SAB_FRACTION_BITS,
    parameter int SIDE_W    = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [FRAC_BITS+1:0] num [3],
    input  logic [FRAC_BITS+1:0] den,
    input  logic [SIDE_W-1:0]    side,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [FRAC_BITS+3:0] quo [3],
    output logic [SIDE_W-1:0]    side_out
);

    localparam int F  = FRAC_BITS;
    localparam int XW = F + 2;
    localparam int QW = F + 4;
    localparam int RW = 2 * F + 6;
    localparam int NS = QW;

    // Stage registers
    logic              vld_reg  [NS];
    logic [RW-1:0]     rem_reg  [NS-1][3];
    logic [QW-1:0]     q_reg    [NS][3];
    logic [XW-1:0]     den_reg  [NS];
    logic [SIDE_W-1:0] side_reg [NS];
    logic [NS-1:0]     en;

    // Stage inputs
    logic [RW-1:0]     st_rem  [NS][3];
    logic [QW-1:0]     st_q    [NS][3];
    logic [XW-1:0]     st_den  [NS];
    logic [SIDE_W-1:0] st_side [NS];
    logic              st_vin  [NS];

    for (genvar j = 0; j < NS; j++) begin : g_stage
        localparam int K = QW - 1 - j;

        logic [RW-1:0] sub;
        logic [RW-1:0] rem_next [3];
        logic [QW-1:0] q_next   [3];

        // Advance when empty or when the next stage moves
        if (j == NS - 1) begin : g_last_en
            assign en[j] = !vld_reg[j] || out_ready;
        end else begin : g_mid_en
            assign en[j] = !vld_reg[j] || en[j+1];
        end

        // Select stage inputs: ports for the first stage
        if (j == 0) begin : g_first
            assign st_vin[j]  = in_valid;
            assign st_den[j]  = den;
            assign st_side[j] = side;
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign st_rem[j][l] = (RW'(num[l]) << F) + RW'(den >> 1);
                assign st_q[j][l]   = '0;
            end
        end else begin : g_next
            assign st_vin[j]  = vld_reg[j-1];
            assign st_den[j]  = den_reg[j-1];
            assign st_side[j] = side_reg[j-1];
            for (genvar l = 0; l < 3; l++) begin : g_lane
                assign st_rem[j][l] = rem_reg[j-1][l];
                assign st_q[j][l]   = q_reg[j-1][l];
            end
        end

        // Try one quotient bit
        assign sub = RW'(st_den[j]) << K;
        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                if (st_rem[j][l] >= sub)
                begin
                    rem_next[l] = st_rem[j][l] - sub;
                    q_next[l]   = st_q[j][l] | (QW'(1) << K);
                end
                else
                begin
                    rem_next[l] = st_rem[j][l];
                    q_next[l]   = st_q[j][l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (en[j])
            begin
                vld_reg[j] <= st_vin[j];
                if (st_vin[j])
                begin
                    den_reg[j]  <= st_den[j];
                    side_reg[j] <= st_side[j];
                    q_reg[j]    <= q_next;
                end
            end
        end

        // Keep the remainder only where a later stage reads it
        if (j < NS - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en[j] && st_vin[j])
                begin
                    rem_reg[j] <= rem_next;
                end
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS-1];
    assign quo       = q_reg[NS-1];
    assign side_out  = side_reg[NS-1];

endmodule

@@ sv/straight_alpha_blend_unit.sv @@
// ----------------------------------------------------------------------------
// straight_alpha_blend_unit
// Straight-alpha RGBA8 blender: normal source-over, erase, add, multiply.
// ----------------------------------------------------------------------------
// Takes one pixel every clock while not stalled and delivers one result beat
// per pixel in order. The pipeline has four front stages (byte to fixed
// point, effective alpha, blend products, mode combine), then a
// FRACTION_BITS + 4 stage pipelined divider that normalizes the source-over
// colors by the output alpha, one quotient bit per stage, then the output
// register that rounds back to bytes. Each stage holds its beat while
// stalled; a stage that is empty takes a new beat, so input stays ready
// while a finished result waits to be taken, as long as a stage is empty.
module straight_alpha_blend_unit
    import sab_pkg::*;
#(
    parameter int FRACTION_BITS = SAB_FRACTION_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    sab_in_if.sink    pix_in,
    sab_out_if.source pix_out
);

    localparam int F  = FRACTION_BITS;
    localparam int UW = F + 1;
    localparam int XW = F + 2;
    localparam int QW = F + 4;
    localparam int SW = 2 + 4 * SAB_BYTE_W + 4 * XW;

    localparam logic [UW-1:0] ONE  = UW'(1) << F;
    localparam logic [UW-1:0] HALF = UW'(1) << (F - 1);
    localparam longint unsigned EPS_L = (longint'(1) << F) / 100000;
    localparam logic [XW-1:0] EPS  = XW'(EPS_L);

    // Rounded fixed-point product
    function automatic logic [UW-1:0] fx_mul(input logic [UW-1:0] a,
                                             input logic [UW-1:0] b);
        logic [2*UW-1:0] p;
        p = (2*UW)'(a) * (2*UW)'(b) + (2*UW)'(HALF);
        return p[F +: UW];
    endfunction

    // Saturate at one, then round to a byte
    function automatic logic [SAB_BYTE_W-1:0] fx_to_byte(input logic [QW-1:0] x);
        logic [UW-1:0]   s;
        logic [UW+7:0]   t;
        s = (x > QW'(ONE)) ? ONE : x[UW-1:0];
        t = ((UW+8)'(s) << 8) - (UW+8)'(s) + (UW+8)'(HALF);
        return t[F +: SAB_BYTE_W];
    endfunction

    // Byte to fixed point lookup, built at elaboration
    logic [UW-1:0] u_tab [256];
    for (genvar g = 0; g < 256; g++) begin : g_tab
        localparam longint unsigned UV = ((longint'(g) << F) + 127) / 255;
        assign u_tab[g] = UW'(UV);
    end

    // Handshake enables
    logic a_en, b_en, c_en, d_en, e_en;
    logic div_in_ready, div_out_valid;

    // Stage A: unorm conversion
    logic                  a_valid_reg;
    blend_mode_t           a_func_reg;
    logic [SAB_BYTE_W-1:0] a_raw_reg [4];
    logic [UW-1:0]         a_ud_reg  [4];
    logic [UW-1:0]         a_us_reg  [4];
    logic [UW-1:0]         a_amt_reg;

    assign a_en         = !a_valid_reg || b_en;
    assign pix_in.ready = a_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_en)
        begin
            a_valid_reg <= pix_in.valid;
            if (pix_in.valid)
            begin
                a_func_reg   <= blend_mode_t'(pix_in.func);
                a_raw_reg[0] <= pix_in.dst_red;
                a_raw_reg[1] <= pix_in.dst_green;
                a_raw_reg[2] <= pix_in.dst_blue;
                a_raw_reg[3] <= pix_in.dst_alpha;
                a_ud_reg[0]  <= u_tab[pix_in.dst_red];
                a_ud_reg[1]  <= u_tab[pix_in.dst_green];
                a_ud_reg[2]  <= u_tab[pix_in.dst_blue];
                a_ud_reg[3]  <= u_tab[pix_in.dst_alpha];
                a_us_reg[0]  <= u_tab[pix_in.src_red];
                a_us_reg[1]  <= u_tab[pix_in.src_green];
                a_us_reg[2]  <= u_tab[pix_in.src_blue];
                a_us_reg[3]  <= u_tab[pix_in.src_alpha];
                a_amt_reg    <= u_tab[pix_in.amount];
            end
        end
    end

    // Stage B: effective alpha and first products
    logic                  b_valid_reg;
    blend_mode_t           b_func_reg;
    logic [SAB_BYTE_W-1:0] b_raw_reg [4];
    logic [UW-1:0]         b_ud_reg  [4];
    logic [UW-1:0]         b_us_reg  [3];
    logic [UW-1:0]         b_sa_reg;
    logic [UW-1:0]         b_pd_reg  [3];
    logic [UW-1:0]         b_pd_next [3];

    assign b_en = !b_valid_reg || c_en;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            b_pd_next[i] = fx_mul(a_ud_reg[i], (a_func_reg == MODE_MULTIPLY) ?
                                  a_us_reg[i] : a_ud_reg[3]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_en)
        begin
            b_valid_reg <= a_valid_reg;
            if (a_valid_reg)
            begin
                b_func_reg <= a_func_reg;
                b_raw_reg  <= a_raw_reg;
                b_ud_reg   <= a_ud_reg;
                b_us_reg   <= a_us_reg[0:2];
                b_sa_reg   <= fx_mul(a_us_reg[3], a_amt_reg);
                b_pd_reg   <= b_pd_next;
            end
        end
    end

    // Stage C: blend products against sa and one minus sa
    logic                  c_valid_reg;
    blend_mode_t           c_func_reg;
    logic [SAB_BYTE_W-1:0] c_raw_reg [4];
    logic [UW-1:0]         c_ud_reg  [4];
    logic [UW-1:0]         c_sa_reg;
    logic                  c_zero_reg;
    logic [UW-1:0]         c_ma_reg  [3];
    logic [UW-1:0]         c_mb_reg  [3];
    logic [UW-1:0]         c_a3_reg;
    logic [UW-1:0]         c_am_reg;
    logic [UW-1:0]         b_inv;
    logic                  b_mult;
    logic [UW-1:0]         c_ma_next [3];
    logic [UW-1:0]         c_mb_next [3];

    assign c_en   = !c_valid_reg || d_en;
    assign b_inv  = ONE - b_sa_reg;
    assign b_mult = (b_func_reg == MODE_MULTIPLY);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_ma_next[i] = fx_mul(b_mult ? b_ud_reg[i] : b_us_reg[i],
                                  b_mult ? b_inv : b_sa_reg);
            c_mb_next[i] = fx_mul(b_pd_reg[i], b_mult ? b_sa_reg : b_inv);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_en)
        begin
            c_valid_reg <= b_valid_reg;
            if (b_valid_reg)
            begin
                c_func_reg <= b_func_reg;
                c_raw_reg  <= b_raw_reg;
                c_ud_reg   <= b_ud_reg;
                c_sa_reg   <= b_sa_reg;
                c_zero_reg <= (b_sa_reg == '0);
                c_ma_reg   <= c_ma_next;
                c_mb_reg   <= c_mb_next;
                c_a3_reg   <= fx_mul(b_ud_reg[3], b_inv);
                c_am_reg   <= fx_mul(b_sa_reg, ONE - b_ud_reg[3]);
            end
        end
    end

    // Stage D: combine per mode, set up the divide
    logic              d_valid_reg;
    logic [XW-1:0]     d_num_reg [3];
    logic [XW-1:0]     d_den_reg;
    logic [SW-1:0]     d_side_reg;
    logic [XW-1:0]     d_num_next [3];
    logic [XW-1:0]     d_col_next [3];
    logic [XW-1:0]     d_alpha_next;
    logic [XW-1:0]     d_oa;
    logic              d_use_div;

    assign d_en = !d_valid_reg || div_in_ready;
    assign d_oa = XW'(c_sa_reg) + XW'(c_a3_reg);

    always_comb
    begin
        d_use_div = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            d_num_next[i] = XW'(c_ma_reg[i]) + XW'(c_mb_reg[i]);
            d_col_next[i] = XW'(c_ud_reg[i]);
        end
        case (c_func_reg)
            MODE_NORMAL:
            begin
                d_use_div    = (d_oa > EPS);
                d_alpha_next = d_oa;
            end
            MODE_ERASE:
            begin
                d_alpha_next = XW'(c_a3_reg);
            end
            MODE_ADD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    d_col_next[i] = XW'(c_ud_reg[i]) + XW'(c_ma_reg[i]);
                end
                d_alpha_next = XW'(c_ud_reg[3]) + XW'(c_sa_reg);
            end
            MODE_MULTIPLY:
            begin
                d_col_next   = d_num_next;
                d_alpha_next = XW'(c_ud_reg[3]) + XW'(c_am_reg);
            end
            default:
            begin
                d_alpha_next = d_oa;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (d_en)
        begin
            d_valid_reg <= c_valid_reg;
            if (c_valid_reg)
            begin
                d_num_reg  <= d_num_next;
                d_den_reg  <= d_oa;
                d_side_reg <= {c_zero_reg, d_use_div,
                               c_raw_reg[0], c_raw_reg[1], c_raw_reg[2], c_raw_reg[3],
                               d_col_next[0], d_col_next[1], d_col_next[2],
                               d_alpha_next};
            end
        end
    end

    // Normalize source-over colors by the output alpha
    logic [QW-1:0] div_quo [3];
    logic [SW-1:0] div_side;

    sab_divider #(
        .FRAC_BITS (F),
        .SIDE_W    (SW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid_reg),
        .in_ready  (div_in_ready),
        .num       (d_num_reg),
        .den       (d_den_reg),
        .side      (d_side_reg),
        .out_valid (div_out_valid),
        .out_ready (e_en),
        .quo       (div_quo),
        .side_out  (div_side)
    );

    // Stage E: pick, clamp and round back to bytes
    logic                  e_valid_reg;
    logic [SAB_BYTE_W-1:0] e_byte_reg [4];
    logic                  e_changed_reg;
    logic                  e_zero;
    logic                  e_use_div;
    logic [SAB_BYTE_W-1:0] e_raw  [4];
    logic [XW-1:0]         e_col  [3];
    logic [XW-1:0]         e_alpha;
    logic [SAB_BYTE_W-1:0] e_byte_next [4];

    assign e_en = !e_valid_reg || pix_out.ready;

    always_comb
    begin
        e_zero    = div_side[SW-1];
        e_use_div = div_side[SW-2];
        for (int i = 0; i < 4; i++)
        begin
            e_raw[i] = div_side[SW-3-SAB_BYTE_W*i -: SAB_BYTE_W];
        end
        for (int i = 0; i < 3; i++)
        begin
            e_col[i] = div_side[XW*(4-i)-1 -: XW];
        end
        e_alpha = div_side[XW-1:0];

        for (int i = 0; i < 3; i++)
        begin
            e_byte_next[i] = fx_to_byte(e_use_div ? div_quo[i] : QW'(e_col[i]));
        end
        e_byte_next[3] = fx_to_byte(QW'(e_alpha));

        // Zero effective alpha passes the destination through
        if (e_zero)
        begin
            e_byte_next = e_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (e_en)
        begin
            e_valid_reg <= div_out_valid;
            if (div_out_valid)
            begin
                e_byte_reg    <= e_byte_next;
                e_changed_reg <= !e_zero;
            end
        end
    end

    assign pix_out.valid     = e_valid_reg;
    assign pix_out.out_red   = e_byte_reg[0];
    assign pix_out.out_green = e_byte_reg[1];
    assign pix_out.out_blue  = e_byte_reg[2];
    assign pix_out.out_alpha = e_byte_reg[3];
    assign pix_out.changed   = e_changed_reg;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the straight-alpha blend unit: a queue-fed driver
// offers pixels, a fixed-point blend predictor computes expected beats, and
// a monitor compares each output beat field by field under random stalls.
// ----------------------------------------------------------------------------
module testbench;
    import sab_pkg::*;

    localparam int FB = SAB_FRACTION_BITS;
    localparam longint unsigned ONE = 64'd1 << FB;
    localparam longint unsigned HALF = 64'd1 << (FB - 1);
    localparam longint unsigned EPS = ONE / 100000;
    localparam int LATENCY = FB + 9;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        blend_mode_t func;
        logic [7:0] dr, dg, db, da, sr, sg, sb, sa, amt;
    } pixel_t;

    typedef struct packed {
        logic [7:0] r, g, b, a;
        logic       chg;
    } blended_t;

    localparam int PIXEL_W = $bits(pixel_t);

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sab_in_if  pix_in ();
    sab_out_if pix_out ();

    straight_alpha_blend_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pix_in (pix_in.sink),
        .pix_out(pix_out.source)
    );

    pixel_t   pending_pixels[$];
    blended_t expected_blends[$];
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       hold_off = 0;
    int       errors = 0;
    int       beats_seen = 0;
    int       mode_count[4] = '{0, 0, 0, 0};
    longint   cycles = 0;

    // Generate the clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned to_fx(logic [7:0] v);
        return (longint'(v) * ONE + 127) / 255;
    endfunction

    function automatic longint unsigned fmul(longint unsigned a, longint unsigned b);
        return (a * b + HALF) >> FB;
    endfunction

    function automatic longint unsigned fsat(longint unsigned a);
        return (a > ONE) ? ONE : a;
    endfunction

    function automatic logic [7:0] to_byte(longint unsigned x);
        longint unsigned t;
        t = (fsat(x) * 255 + HALF) >> FB;
        return t[7:0];
    endfunction

    // Predict the blended pixel for one input beat
    function automatic blended_t blend_pixel(pixel_t p);
        longint unsigned d[4], s[4];
        longint unsigned eff, inv, oa, n;
        blended_t res;
        d[0] = to_fx(p.dr); d[1] = to_fx(p.dg); d[2] = to_fx(p.db); d[3] = to_fx(p.da);
        s[0] = to_fx(p.sr); s[1] = to_fx(p.sg); s[2] = to_fx(p.sb); s[3] = to_fx(p.sa);
        eff = fmul(s[3], to_fx(p.amt));
        if (eff == 0)
        begin
            res = '{p.dr, p.dg, p.db, p.da, 1'b0};
            return res;
        end
        inv = ONE - eff;
        case (p.func)
            MODE_ERASE:
                d[3] = fmul(d[3], inv);
            MODE_ADD:
            begin
                for (int i = 0; i < 3; i++)
                    d[i] = fsat(d[i] + fmul(s[i], eff));
                d[3] = fsat(d[3] + eff);
            end
            MODE_MULTIPLY:
            begin
                for (int i = 0; i < 3; i++)
                    d[i] = fmul(d[i], inv) + fmul(fmul(d[i], s[i]), eff);
                d[3] = fsat(d[3] + fmul(eff, ONE - fsat(d[3])));
            end
            default:
            begin
                oa = eff + fmul(d[3], inv);
                if (oa > EPS)
                    for (int i = 0; i < 3; i++)
                    begin
                        n = fmul(s[i], eff) + fmul(fmul(d[i], d[3]), inv);
                        d[i] = (n * ONE + oa / 2) / oa;
                    end
                d[3] = oa;
            end
        endcase
        res = '{to_byte(d[0]), to_byte(d[1]), to_byte(d[2]), to_byte(d[3]), 1'b1};
        return res;
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t p;
        p = pixel_t'(PIXEL_W'({$urandom(), $urandom(), $urandom()}));
        // Bias alpha and amount toward the edges now and then
        case ($urandom_range(0, 7))
            0: p.sa = 8'd0;
            1: p.amt = 8'd255;
            2: p.da = 8'($urandom_range(0, 2));
            3: p.sa = 8'($urandom_range(0, 3));
            default: ;
        endcase
        return p;
    endfunction

    // Drive the input channel from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_in.valid <= 1'b0;
            {pix_in.func, pix_in.dst_red, pix_in.dst_green, pix_in.dst_blue,
             pix_in.dst_alpha, pix_in.src_red, pix_in.src_green, pix_in.src_blue,
             pix_in.src_alpha, pix_in.amount} <= '0;
        end
        else if (!pix_in.valid || pix_in.ready)
        begin
            if (pix_in.valid)
            begin
                expected_blends.insert(expected_blends.size(), blend_pixel(pixel_t'({
                    pix_in.func,
                    pix_in.dst_red, pix_in.dst_green, pix_in.dst_blue, pix_in.dst_alpha,
                    pix_in.src_red, pix_in.src_green, pix_in.src_blue, pix_in.src_alpha,
                    pix_in.amount})));
                mode_count[pix_in.func]++;
            end
            if (pending_pixels.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                pixel_t p;
                p = pending_pixels.pop_front();
                pix_in.valid <= 1'b1;
                {pix_in.func, pix_in.dst_red, pix_in.dst_green, pix_in.dst_blue,
                 pix_in.dst_alpha, pix_in.src_red, pix_in.src_green, pix_in.src_blue,
                 pix_in.src_alpha, pix_in.amount} <= p;
            end
            else
                pix_in.valid <= 1'b0;
        end
    end

    // Monitor the output channel and pick the next ready level
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_out.ready <= 1'b0;
        else
        begin
            cycles++;
            if (pix_out.valid && pix_out.ready)
            begin
                blended_t got, want;
                got = '{pix_out.out_red, pix_out.out_green, pix_out.out_blue,
                        pix_out.out_alpha, pix_out.changed};
                beats_seen++;
                if (expected_blends.size() == 0)
                begin
                    $display("%0t: unexpected beat, actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_blends.pop_front();
                    if (got.r !== want.r)
                        $display("%0t: red exp %0d act %0d", $time, want.r, got.r);
                    if (got.g !== want.g)
                        $display("%0t: green exp %0d act %0d", $time, want.g, got.g);
                    if (got.b !== want.b)
                        $display("%0t: blue exp %0d act %0d", $time, want.b, got.b);
                    if (got.a !== want.a)
                        $display("%0t: alpha exp %0d act %0d", $time, want.a, got.a);
                    if (got.chg !== want.chg)
                        $display("%0t: changed exp %0d act %0d", $time, want.chg, got.chg);
                    if (got !== want)
                        errors++;
                end
            end
            if (hold_off > 0)
            begin
                hold_off--;
                pix_out.ready <= 1'b0;
            end
            else
                pix_out.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_pixels.size() > 0 || pix_in.valid || expected_blends.size() > 0)
            @(posedge clk);
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++)
            pending_pixels.insert(pending_pixels.size(), rand_pixel());
    endtask

    initial
    begin
        pixel_t p;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every mode at the extremes, zero effective alpha, tiny alpha
        for (int m = 0; m < 4; m++)
        begin
            pending_pixels.insert(pending_pixels.size(),
                                  pixel_t'({2'(m), {9{8'hFF}}}));
            pending_pixels.insert(pending_pixels.size(),
                                  pixel_t'({2'(m), {9{8'h00}}}));
            pending_pixels.insert(pending_pixels.size(),
                                  pixel_t'({2'(m), 8'h12, 8'h34, 8'h56, 8'h00,
                                            8'hAB, 8'hCD, 8'hEF, 8'h01, 8'h01}));
            pending_pixels.insert(pending_pixels.size(),
                                  pixel_t'({2'(m), 8'hFF, 8'h00, 8'h80, 8'h80,
                                            8'h00, 8'hFF, 8'h7F, 8'hFF, 8'h00}));
            pending_pixels.insert(pending_pixels.size(),
                                  pixel_t'({2'(m), 8'h55, 8'hAA, 8'h01, 8'hFE,
                                            8'hAA, 8'h55, 8'hFE, 8'h80, 8'hFF}));
        end
        p = pixel_t'({MODE_NORMAL, 8'h40, 8'h80, 8'hC0, 8'h00, 8'h11, 8'h22,
                      8'h33, 8'h02, 8'h80});
        pending_pixels.insert(pending_pixels.size(), p);
        wait_drained();

        // Phase one: sender mostly busy, receiver slow, with a long hold-off at the start
        send_idle_pct = 31;
        recv_idle_pct = 65;
        queue_random(200);
        hold_off = 120;
        wait_drained();

        // Phase two: roles swapped
        send_idle_pct = 65;
        recv_idle_pct = 31;
        queue_random(200);
        wait_drained();

        // Phase three: full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(300);
        wait_drained();
        repeat (LATENCY * 2) @(posedge clk);

        $display("covered %0d beats: normal %0d erase %0d add %0d multiply %0d",
                 beats_seen, mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
        if (errors == 0 && expected_blends.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

@@ files.f @@
sv/sab_pkg.sv
sv/sab_in_if.sv
sv/sab_out_if.sv
sv/sab_divider.sv
sv/straight_alpha_blend_unit.sv
tb/testbench.sv
